// ===== src/lpri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpri_pkg
// Shared widths, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lpri_pkg;

  localparam int CRD_W = 20;   // input coordinate width
  localparam int ECHO_W = 8;
  localparam int ROW_W = 7;
  localparam int COL_W = 12;
  localparam int RNG_W = 20;
  localparam int OFF_W = 17;
  localparam int PER_W = 24;
  localparam int RCNT_W = 8;
  localparam int CCNT_W = 13;
  localparam int CNT_W = 14;   // holds any clamp limit
  localparam int IDX_W = 13;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 48;

  localparam int CW = 36;      // CORDIC datapath width
  localparam int ACC_W = 27;   // angle accumulator, 1/65536 degree
  localparam int ANG_W = ACC_W - 8;  // angle, 1/256 degree
  localparam int PRE_SHIFT = 12;

  localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 * 65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLAR_OFF = 3'd0,
    REG_AZIM_OFF  = 3'd1,
    REG_ROWS_PER  = 3'd2,
    REG_COLS_PER  = 3'd3,
    REG_ROW_CNT   = 3'd4,
    REG_COL_CNT   = 3'd5
  } cfg_reg_e;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [23:0] ATAN_DEG_Q16 [32] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945,
    24'd234379,  24'd117304,  24'd58666,  24'd29335,
    24'd14668,   24'd7334,    24'd3667,   24'd1833,
    24'd917,     24'd458,     24'd229,    24'd115,
    24'd57,      24'd29,      24'd14,     24'd7,
    24'd4,       24'd2,       24'd1,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0
  };

endpackage

// ===== src/lpri_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpri_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module lpri_sqrt #(
  parameter int IN_W = 40
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     rad_i,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int OUT_W = IN_W / 2;

  logic [IN_W-1:0]  rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int I = OUT_W - 1 - k;
    logic [IN_W-1:0]  rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = ((IN_W+1)'(root_in) << (I + 1)) | ((IN_W+1)'(1) << (2 * I));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[IN_W-1:0];
          root_q[k] <= root_in | (OUT_W'(1) << I);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[OUT_W-1];

endmodule

// ===== src/lpri_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpri_cordic
// Pipelined vectoring CORDIC: atan2(b, a) in 1/256 degree, rounded.
// ----------------------------------------------------------------------------
module lpri_cordic import lpri_pkg::*; #(
  parameter int STEPS = 20
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CW-1:0]    a_i,
  input  logic signed [CW-1:0]    b_i,
  output logic signed [ANG_W-1:0] angle_o
);

  logic signed [CW-1:0]    a_q   [STEPS+1];
  logic signed [CW-1:0]    b_q   [STEPS+1];
  logic signed [ACC_W-1:0] acc_q [STEPS+1];
  logic signed [ACC_W-1:0] rnd;
  logic signed [ANG_W-1:0] angle_q;

  // left half plane: turn by 180 degrees first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (a_i[CW-1]) begin
        a_q[0]   <= -a_i;
        b_q[0]   <= -b_i;
        acc_q[0] <= b_i[CW-1] ? -DEG180 : DEG180;
      end else begin
        a_q[0]   <= a_i;
        b_q[0]   <= b_i;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [ACC_W-1:0] ang;
    assign ang = $signed(ACC_W'(ATAN_DEG_Q16[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (b_q[i] == '0) begin
          a_q[i+1]   <= a_q[i];
          b_q[i+1]   <= b_q[i];
          acc_q[i+1] <= acc_q[i];
        end else if (!b_q[i][CW-1]) begin
          a_q[i+1]   <= a_q[i] + (b_q[i] >>> i);
          b_q[i+1]   <= b_q[i] - (a_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] + ang;
        end else begin
          a_q[i+1]   <= a_q[i] - (b_q[i] >>> i);
          b_q[i+1]   <= b_q[i] + (a_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] - ang;
        end
      end
    end
  end

  assign rnd = acc_q[STEPS] + ACC_W'(128);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= rnd[ACC_W-1:8];
    end
  end

  assign angle_o = angle_q;

endmodule

// ===== src/lidar_point_range_image_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_range_image_projection
// Lidar point to range-image row/column projection, fully pipelined.
// ----------------------------------------------------------------------------
// Path: the 32-stage root of (x^2+y^2)<<24, the CORDIC stages and the
//   multiply/clamp stages, from accept to m_axis_tvalid.
// Throughput: one word per cycle while the skid word is empty; a two-entry
//   output buffer decouples the pipeline from downstream stalls.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module lidar_point_range_image_projection import lpri_pkg::*; #(
  parameter int MAX_ROWS     = 128,
  parameter int MAX_COLS     = 4096,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // x_pos[19:0], y_pos[39:20], z_pos[59:40], echo_strength[67:60]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_index[6:0], col_index[18:7], range_value[38:19], echo_out[46:39]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate[0]
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int CIN = 34;                 // stage feeding the CORDICs
  localparam int FIN = CORDIC_STEPS + 38;  // last pipeline stage
  localparam int RNG0 = 22;                // stage of range root output

  typedef struct packed {
    logic [ECHO_W-1:0] echo;
    logic              degen;
  } side_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [RNG_W-1:0]  rng;
    logic [ECHO_W-1:0] echo;
    logic              degen;
  } res_t;

  // configuration
  logic signed [OFF_W-1:0] polar_off_q, azim_off_q;
  logic [PER_W-1:0]        rows_per_q, cols_per_q;
  logic [RCNT_W-1:0]       row_cnt_q;
  logic [CCNT_W-1:0]       col_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polar_off_q <= '0;
      azim_off_q  <= OFF_W'(46080);
      rows_per_q  <= PER_W'(163840);
      cols_per_q  <= PER_W'(327680);
      row_cnt_q   <= RCNT_W'(64);
      col_cnt_q   <= CCNT_W'(1800);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_POLAR_OFF: polar_off_q <= cfg_wdata_i[OFF_W-1:0];
        REG_AZIM_OFF:  azim_off_q  <= cfg_wdata_i[OFF_W-1:0];
        REG_ROWS_PER:  rows_per_q  <= cfg_wdata_i[PER_W-1:0];
        REG_COLS_PER:  cols_per_q  <= cfg_wdata_i[PER_W-1:0];
        REG_ROW_CNT:   row_cnt_q   <= cfg_wdata_i[RCNT_W-1:0];
        REG_COL_CNT:   col_cnt_q   <= cfg_wdata_i[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CNT_W-1:0] lim_of(logic [CNT_W-1:0] cnt,
                                               logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] eff;
    if (cnt == '0) eff = CNT_W'(1);
    else if (cnt > maxv) eff = maxv;
    else eff = cnt;
    return eff - CNT_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(logic signed [20:0] idx,
                                                 logic [CNT_W-1:0] lim);
    if (idx[20]) return '0;
    else if (idx[19:0] > 20'(lim)) return lim[IDX_W-1:0];
    else return idx[IDX_W-1:0];
  endfunction

  logic [CNT_W-1:0] row_lim, col_lim;
  assign row_lim = lim_of(CNT_W'(row_cnt_q), CNT_W'(MAX_ROWS));
  assign col_lim = lim_of(CNT_W'(col_cnt_q), CNT_W'(MAX_COLS));

  // flow control
  logic en;
  logic skid_vld_q, out_vld_q;
  res_t skid_q, out_q;
  logic [FIN:0] vld_q;

  assign en = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FIN-1:0], s_axis_tvalid};
    end
  end

  // input and side lines
  logic signed [CRD_W-1:0] x_q [CIN+1];
  logic signed [CRD_W-1:0] y_q [CIN+1];
  logic signed [CRD_W-1:0] z_q [CIN+1];
  side_t                   side_q [FIN+1];
  logic signed [CRD_W-1:0] x_in, y_in, z_in;

  assign x_in = s_axis_tdata[19:0];
  assign y_in = s_axis_tdata[39:20];
  assign z_in = s_axis_tdata[59:40];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= x_in;
      y_q[0] <= y_in;
      z_q[0] <= z_in;
      side_q[0].echo  <= s_axis_tdata[67:60];
      side_q[0].degen <= (x_in == '0) && (y_in == '0) && (z_in == '0);
      for (int k = 1; k <= CIN; k++) begin
        x_q[k] <= x_q[k-1];
        y_q[k] <= y_q[k-1];
        z_q[k] <= z_q[k-1];
      end
      for (int k = 1; k <= FIN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // squares and sums
  logic [39:0] xx_q, yy_q, zz_q, sxy_q, s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q  <= 40'(x_q[0] * x_q[0]);
      yy_q  <= 40'(y_q[0] * y_q[0]);
      zz_q  <= 40'(z_q[0] * z_q[0]);
      sxy_q <= xx_q + yy_q;
      s_q   <= xx_q + yy_q + zz_q;
    end
  end

  logic [31:0]      rxy;
  logic [RNG_W-1:0] rng_root;

  lpri_sqrt #(.IN_W(64)) u_rxy_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({sxy_q, 24'd0}),
    .root_o (rxy)
  );

  lpri_sqrt #(.IN_W(40)) u_rng_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s_q),
    .root_o (rng_root)
  );

  logic [RNG_W-1:0] rng_q [FIN-RNG0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q[0] <= rng_root;
      for (int k = 1; k < FIN - RNG0; k++) begin
        rng_q[k] <= rng_q[k-1];
      end
    end
  end

  // angles
  logic signed [ANG_W-1:0] polar, azim;

  lpri_cordic #(.STEPS(CORDIC_STEPS)) u_polar (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     ($signed(CW'(z_q[CIN])) <<< PRE_SHIFT),
    .b_i     ($signed(CW'(rxy))),
    .angle_o (polar)
  );

  lpri_cordic #(.STEPS(CORDIC_STEPS)) u_azim (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     ($signed(CW'(x_q[CIN])) <<< PRE_SHIFT),
    .b_i     ($signed(CW'(y_q[CIN])) <<< PRE_SHIFT),
    .angle_o (azim)
  );

  // offset, scale, clamp
  logic signed [ANG_W:0]   n_row, n_col;
  logic signed [44:0]      prod_row_q, prod_col_q;
  logic [IDX_W-1:0]        row_q, col_q;

  assign n_row = (ANG_W+1)'(polar) + (ANG_W+1)'(polar_off_q);
  assign n_col = (ANG_W+1)'(azim) + (ANG_W+1)'(azim_off_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_row_q <= n_row * $signed({1'b0, rows_per_q});
      prod_col_q <= n_col * $signed({1'b0, cols_per_q});
      if (side_q[FIN-1].degen) begin
        row_q <= '0;
        col_q <= '0;
      end else begin
        row_q <= clamp_idx(prod_row_q[44:24], row_lim);
        col_q <= clamp_idx(prod_col_q[44:24], col_lim);
      end
    end
  end

  res_t fin;
  assign fin.row   = row_q[ROW_W-1:0];
  assign fin.col   = col_q[COL_W-1:0];
  assign fin.rng   = rng_q[FIN-RNG0-1];
  assign fin.echo  = side_q[FIN].echo;
  assign fin.degen = side_q[FIN].degen;

  // output register and skid word
  logic out_take;
  assign out_take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) skid_vld_q <= 1'b0;
    end else if (vld_q[FIN]) begin
      if (out_vld_q && !m_axis_tready) skid_vld_q <= 1'b1;
      else out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (vld_q[FIN]) begin
      if (out_vld_q && !m_axis_tready) skid_q <= fin;
      else out_q <= fin;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.degen;
  assign m_axis_tdata  = {1'b0, out_q.echo, out_q.rng, out_q.col, out_q.row};

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid word without output word");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid filled without stall");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.degen) |-> (out_q.row == '0 && out_q.col == '0
      && out_q.rng == '0)) else $error("degenerate point with nonzero fields");

  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (CNT_W'(out_q.row) <= row_lim))
    else $error("row beyond image");

endmodule

// ===== bench/lidar_point_range_image_projection_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_range_image_projection_tb
// Self-checking bench for the lidar point to range-image projection.
// A short directed table (origin, axes, coordinate extremes, the 180 degree
// wrap) runs first. Then random points go through four register settings,
// extremes included, with random gaps on the input and stalls on the output.
// Every output word is checked field by field against a bit-exact model or a stored word.
// ----------------------------------------------------------------------------
module lidar_point_range_image_projection_tb;
  import lpri_pkg::*;

  localparam int CORDIC_STEPS = 20;
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int PIPE_TAIL = 80;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [RNG_W-1:0]  rng;
    logic [ECHO_W-1:0] echo;
    logic              degen;
  } pixel_t;

  typedef struct {
    logic [CRD_W-1:0]  x, y, z;
    logic [ECHO_W-1:0] e;
    bit                typed;
    pixel_t            px;
  } stim_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  logic [OFF_W-1:0]  polar_off, azim_off;
  logic [PER_W-1:0]  rows_per, cols_per;
  logic [RCNT_W-1:0] row_cnt;
  logic [CCNT_W-1:0] col_cnt;

  pixel_t pixel_q[$];
  int     err_cnt = 0;
  int     tx_gap_pct = 0;
  int     rx_stall_pct = 0;
  int     quiet_cycles = 0;

  lidar_point_range_image_projection #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // atan2(b, a) in 1/256 degree
  function automatic longint vector_angle(longint b, longint a);
    longint acc = 0;
    longint t;
    if (a < 0) begin
      acc = (b >= 0) ? 180 * 65536 : -180 * 65536;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (b == 0) break;
      if (b > 0) begin
        t = a + (b >>> i);
        b = b - (a >>> i);
        acc += longint'(ATAN_DEG_Q16[i]);
      end else begin
        t = a - (b >>> i);
        b = b + (a >>> i);
        acc -= longint'(ATAN_DEG_Q16[i]);
      end
      a = t;
    end
    return (acc + 128) >>> 8;
  endfunction

  function automatic longint pixel_index(longint ang, logic [OFF_W-1:0] off,
                                         logic [PER_W-1:0] per, longint cnt,
                                         longint lim);
    longint n = ang + longint'($signed(off));
    longint idx = (n * longint'({1'b0, per})) >>> 24;
    if (cnt == 0) cnt = 1;
    if (cnt > lim) cnt = lim;
    if (idx < 0) idx = 0;
    if (idx > cnt - 1) idx = cnt - 1;
    return idx;
  endfunction

  function automatic pixel_t project_point(logic [CRD_W-1:0] xp, logic [CRD_W-1:0] yp,
                                           logic [CRD_W-1:0] zp, logic [ECHO_W-1:0] e);
    pixel_t p;
    longint x = longint'($signed(xp));
    longint y = longint'($signed(yp));
    longint z = longint'($signed(zp));
    longint unsigned sxy = x * x + y * y;
    longint unsigned s = sxy + z * z;
    longint unsigned r = int_root(s);
    longint rxy;
    p = '0;
    p.echo = e;
    p.rng = (r > 1048575) ? 20'hFFFFF : r[RNG_W-1:0];
    if (s == 0) begin
      p.degen = 1'b1;
    end else begin
      rxy = longint'(int_root(sxy << 24));
      p.row = ROW_W'(pixel_index(vector_angle(rxy, z * 4096), polar_off, rows_per,
                                 longint'(row_cnt), MAX_ROWS));
      p.col = COL_W'(pixel_index(vector_angle(y * 4096, x * 4096), azim_off, cols_per,
                                 longint'(col_cnt), MAX_COLS));
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    err_cnt++;
  endtask

  task automatic write_regs(input cfg_reg_e idx[], input logic [CFG_DATA_W-1:0] val[]);
    foreach (idx[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        REG_POLAR_OFF: polar_off = val[i][OFF_W-1:0];
        REG_AZIM_OFF:  azim_off = val[i][OFF_W-1:0];
        REG_ROWS_PER:  rows_per = val[i][PER_W-1:0];
        REG_COLS_PER:  cols_per = val[i][PER_W-1:0];
        REG_ROW_CNT:   row_cnt = val[i][RCNT_W-1:0];
        REG_COL_CNT:   col_cnt = val[i][CCNT_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(stim_t st);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, st.e, st.z, st.y, st.x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixel_q.insert(pixel_q.size(),
                   st.typed ? st.px : project_point(st.x, st.y, st.z, st.e));
  endtask

  function automatic logic [CRD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return '0;
      1, 2: return CRD_W'($signed($urandom_range(4094)) - 2047);
      default: return CRD_W'($urandom);
    endcase
  endfunction

  task automatic random_points(int n);
    stim_t st;
    for (int k = 0; k < n; k++) begin
      st.typed = 1'b0;
      st.e = ECHO_W'($urandom);
      st.x = rand_coord();
      st.y = rand_coord();
      st.z = rand_coord();
      case ($urandom_range(9))
        0: begin st.x = '0; st.y = '0; st.z = '0; end
        1: begin
          st.x = CRD_W'(-$urandom_range(524288, 1));
          st.y = CRD_W'(int'($urandom_range(2)) - 1);
        end
        default: ;
      endcase
      send_point(st);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    pixel_t got, want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[6:0], m_axis_tdata[18:7], m_axis_tdata[38:19],
             m_axis_tdata[46:39], m_axis_tuser};
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 1);
      end else begin
        want = pixel_q.pop_front();
        if (got.row !== want.row) report_mismatch("row_index", want.row, got.row);
        if (got.col !== want.col) report_mismatch("col_index", want.col, got.col);
        if (got.rng !== want.rng) report_mismatch("range_value", want.rng, got.rng);
        if (got.echo !== want.echo) report_mismatch("echo_out", want.echo, got.echo);
        if (got.degen !== want.degen) report_mismatch("degenerate", want.degen, got.degen);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("lidar_point_range_image_projection_tb: errors");
    $finish;
  end

  initial begin
    stim_t dir_tbl[$];
    cfg_reg_e all_regs[] = '{REG_POLAR_OFF, REG_AZIM_OFF, REG_ROWS_PER, REG_COLS_PER,
                             REG_ROW_CNT, REG_COL_CNT, cfg_reg_e'(3'd6), cfg_reg_e'(3'd7)};
    polar_off = '0;
    azim_off = 17'd46080;
    rows_per = 24'd163840;
    cols_per = 24'd327680;
    row_cnt = 8'd64;
    col_cnt = 13'd1800;
    // origin rows carry their expected word; the rest go through the model
    dir_tbl = '{
      '{'0, '0, '0, 8'h00, 1'b1, '{'0, '0, '0, 8'h00, 1'b1}},
      '{'0, '0, '0, 8'hFF, 1'b1, '{'0, '0, '0, 8'hFF, 1'b1}},
      '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 8'hFF, 1'b0, '0},
      '{20'h80000, 20'h80000, 20'h80000, 8'h00, 1'b0, '0},
      '{20'h7FFFF, 20'h80000, 20'h7FFFF, 8'h5A, 1'b0, '0},
      '{20'd256, '0, '0, 8'h01, 1'b0, '0},
      '{20'hFFF00, '0, '0, 8'h02, 1'b0, '0},
      '{20'hFFF00, 20'hFFFFF, '0, 8'h03, 1'b0, '0},
      '{'0, 20'd256, '0, 8'h04, 1'b0, '0},
      '{'0, 20'hFFF00, '0, 8'h05, 1'b0, '0},
      '{'0, '0, 20'd256, 8'h06, 1'b0, '0},
      '{'0, '0, 20'hFFF00, 8'h07, 1'b0, '0},
      '{20'hFFFFF, '0, '0, 8'h08, 1'b0, '0},
      '{20'h80000, '0, '0, 8'h09, 1'b0, '0},
      '{'0, 20'h80000, 20'h7FFFF, 8'hA5, 1'b0, '0},
      '{20'd1, 20'd1, 20'd1, 8'h80, 1'b0, '0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_point(dir_tbl[i]);
    s_axis_tvalid <= 1'b0;

    tx_gap_pct = 22;
    rx_stall_pct = 68;
    random_points(150);
    drain();

    write_regs(all_regs, '{24'hFF4C00, 24'h01B400, 24'hFFFFFF, 24'd1, 24'd0, 24'd0,
                           24'h123456, 24'hABCDEF});
    tx_gap_pct = 68;
    rx_stall_pct = 22;
    random_points(150);
    drain();

    write_regs(all_regs, '{24'd46080, 24'h0, 24'd0, 24'hFFFFFF, 24'hFF, 24'h1FFF,
                           24'h0, 24'hFFFFFF});
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    random_points(150);
    drain();

    write_regs(all_regs, '{24'($urandom_range(92160)) - 24'd46080,
                           24'($urandom_range(92160)) - 24'd46080,
                           24'($urandom_range(400000, 30000)),
                           24'($urandom_range(400000, 30000)),
                           24'd128, 24'd4096, 24'($urandom), 24'($urandom)});
    random_points(150);

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_TAIL) @(posedge clk_i);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("lidar_point_range_image_projection_tb: clean");
    end else begin
      $display("lidar_point_range_image_projection_tb: errors");
    end
    $finish;
  end

endmodule

// ===== lidar_point_range_image_projection.f =====
src/lpri_pkg.sv
src/lpri_sqrt.sv
src/lpri_cordic.sv
src/lidar_point_range_image_projection.sv
bench/lidar_point_range_image_projection_tb.sv
